// File: design/dipi_pkg.sv
// Shared constants and types for the dual incremental PI H-bridge PWM block.
`default_nettype none

package dipi_pkg;

    localparam int unsigned PWM_PERIOD_DEFAULT = 7200;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_CENTER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_SPAN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT     = 3'd5;

    localparam logic [13:0] SERVO_CENTER_RESET = 14'd750;
    localparam logic [12:0] SERVO_SPAN_RESET   = 13'd500;
    localparam logic [12:0] DRIVE_LIMIT_RESET  = 13'd6900;

    typedef struct packed {
        logic s2;
        logic s3;
    } adv_t;

endpackage

`default_nettype wire

// File: design/dipi_wheel.sv
// One wheel: incremental PI accumulator with saturation and H-bridge compare mapping.
`default_nettype none

module dipi_wheel #(
    parameter int unsigned PWM_PERIOD = dipi_pkg::PWM_PERIOD_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dipi_pkg::adv_t     adv,
    input  logic signed [15:0] count,
    input  logic signed [15:0] goal,
    input  logic        [15:0] gain_p,
    input  logic        [15:0] gain_i,
    input  logic        [12:0] drive_lim,
    output logic        [12:0] high_compare,
    output logic        [12:0] low_compare
);

    localparam logic signed [17:0] PERIOD_S = 18'(PWM_PERIOD);
    localparam logic signed [36:0] SUM_MAX  = 37'sd2147483647;
    localparam logic signed [36:0] SUM_MIN  = -37'sd2147483648;

    logic signed [16:0] prev_err_reg;
    logic signed [34:0] prod_p_reg;
    logic signed [33:0] prod_i_reg;
    logic signed [31:0] acc_reg;

    logic signed [16:0] err;
    logic signed [17:0] diff;
    logic signed [34:0] prod_p_next;
    logic signed [33:0] prod_i_next;
    logic signed [36:0] sum;
    logic signed [31:0] acc_next;
    logic signed [31:0] lim_s;
    logic signed [31:0] lim_neg;
    logic signed [13:0] drive;
    logic signed [17:0] drive_ext;
    logic signed [17:0] high_full;
    logic signed [17:0] low_full;

    assign err         = {goal[15], goal} - {count[15], count};
    assign diff        = {err[16], err} - {prev_err_reg[16], prev_err_reg};
    assign prod_p_next = $signed({1'b0, gain_p}) * diff;
    assign prod_i_next = $signed({1'b0, gain_i}) * err;

    assign sum = 37'(acc_reg) + 37'(prod_p_reg) + 37'(prod_i_reg);

    always_comb
    begin
        priority if (sum > SUM_MAX)
        begin
            acc_next = 32'sh7FFFFFFF;
        end
        else if (sum < SUM_MIN)
        begin
            acc_next = 32'sh80000000;
        end
        else
        begin
            acc_next = sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            if (adv.s2)
            begin
                prev_err_reg <= err;
            end
            if (adv.s3)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
        end
    end

    // The drive is the accumulator clamped to plus or minus the limit.
    assign lim_s   = $signed({19'b0, drive_lim});
    assign lim_neg = -lim_s;

    always_comb
    begin
        priority if (acc_reg < lim_neg)
        begin
            drive = lim_neg[13:0];
        end
        else if (acc_reg > lim_s)
        begin
            drive = lim_s[13:0];
        end
        else
        begin
            drive = acc_reg[13:0];
        end
    end

    assign drive_ext = {{4{drive[13]}}, drive};
    assign high_full = PERIOD_S - drive_ext;
    assign low_full  = PERIOD_S + drive_ext;

    always_comb
    begin
        if (drive[13])
        begin
            high_compare = PERIOD_S[12:0];
            low_compare  = low_full[12:0];
        end
        else
        begin
            high_compare = high_full[12:0];
            low_compare  = PERIOD_S[12:0];
        end
    end

endmodule

`default_nettype wire

// File: design/dual_incremental_pi_hbridge_pwm.sv
// Top level: two-wheel incremental PI controller with H-bridge PWM, servo clamp and brake.
// An accepted beat passes the input, product, accumulator and result registers in order.
// Throughput: one input beat per cycle; the four-stage pipeline holds up to four items
// and stalls stage by stage from the output register back when out_ready is low.
// The PI accumulators close their loop in the third stage, one add and saturate per cycle.
// Reset clears all valid flags, accumulators, previous errors and the direction flag,
// and loads the configuration registers with their reset values.
`default_nettype none

module dual_incremental_pi_hbridge_pwm #(
    parameter int unsigned PWM_PERIOD = dipi_pkg::PWM_PERIOD_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dipi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [15:0]             count_left,
    input  logic signed [15:0]             count_right,
    input  logic signed [15:0]             goal_left,
    input  logic signed [15:0]             goal_right,
    input  logic        [13:0]             servo_command,
    input  logic        [15:0]             measured_distance,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic        [12:0]             left_high_compare,
    output logic        [12:0]             left_low_compare,
    output logic        [12:0]             right_high_compare,
    output logic        [12:0]             right_low_compare,
    output logic        [13:0]             servo_out,
    output logic                           braking
);

    localparam logic [12:0] PERIOD_13 = 13'(PWM_PERIOD);
    localparam logic [15:0] PERIOD_16 = 16'(PWM_PERIOD);

    logic [15:0] speed_gain_p_reg;
    logic [15:0] speed_gain_i_reg;
    logic [15:0] target_distance_reg;
    logic [13:0] servo_center_reg;
    logic [12:0] servo_span_reg;
    logic [12:0] drive_limit_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic prev_dir_reg;

    logic signed [15:0] count_left_reg;
    logic signed [15:0] count_right_reg;
    logic signed [15:0] goal_left_reg;
    logic signed [15:0] goal_right_reg;
    logic        [13:0] servo_cmd_reg;
    logic        [15:0] distance_reg;

    logic        brake2_reg;
    logic [13:0] servo2_reg;
    logic        brake3_reg;
    logic [13:0] servo3_reg;

    logic [12:0] left_high_reg;
    logic [12:0] left_low_reg;
    logic [12:0] right_high_reg;
    logic [12:0] right_low_reg;
    logic [13:0] servo_out_reg;
    logic        braking_reg;

    dipi_pkg::adv_t adv;
    logic           adv4;
    logic           in_fire;
    logic           dir;
    logic           brake_next;
    logic [12:0]    drive_lim;
    logic signed [15:0] servo_lo;
    logic signed [15:0] servo_hi;
    logic signed [15:0] servo_cmd_s;
    logic signed [15:0] servo_raised;
    logic signed [15:0] servo_clamped;
    logic [13:0]    servo_next;
    logic [12:0]    lw_high;
    logic [12:0]    lw_low;
    logic [12:0]    rw_high;
    logic [12:0]    rw_low;

    // Configuration port.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_p_reg    <= '0;
            speed_gain_i_reg    <= '0;
            target_distance_reg <= '0;
            servo_center_reg    <= dipi_pkg::SERVO_CENTER_RESET;
            servo_span_reg      <= dipi_pkg::SERVO_SPAN_RESET;
            drive_limit_reg     <= dipi_pkg::DRIVE_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dipi_pkg::CFG_SPEED_GAIN_P:    speed_gain_p_reg    <= cfg_data;
                dipi_pkg::CFG_SPEED_GAIN_I:    speed_gain_i_reg    <= cfg_data;
                dipi_pkg::CFG_TARGET_DISTANCE: target_distance_reg <= cfg_data;
                dipi_pkg::CFG_SERVO_CENTER:    servo_center_reg    <= cfg_data[13:0];
                dipi_pkg::CFG_SERVO_SPAN:      servo_span_reg      <= cfg_data[12:0];
                dipi_pkg::CFG_DRIVE_LIMIT:     drive_limit_reg     <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    // Pipeline flow control.
    assign adv4     = v3_reg && (!v4_reg || out_ready);
    assign adv.s3   = v2_reg && (!v3_reg || adv4);
    assign adv.s2   = v1_reg && (!v2_reg || adv.s3);
    assign in_ready = !v1_reg || adv.s2;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            prev_dir_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                v1_reg <= 1'b1;
            end
            else if (adv.s2)
            begin
                v1_reg <= 1'b0;
            end
            if (adv.s2)
            begin
                v2_reg       <= 1'b1;
                prev_dir_reg <= dir;
            end
            else if (adv.s3)
            begin
                v2_reg <= 1'b0;
            end
            if (adv.s3)
            begin
                v3_reg <= 1'b1;
            end
            else if (adv4)
            begin
                v3_reg <= 1'b0;
            end
            if (adv4)
            begin
                v4_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                v4_reg <= 1'b0;
            end
        end
    end

    // Stage 1: input register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            count_left_reg  <= count_left;
            count_right_reg <= count_right;
            goal_left_reg   <= goal_left;
            goal_right_reg  <= goal_right;
            servo_cmd_reg   <= servo_command;
            distance_reg    <= measured_distance;
        end
    end

    // Direction change and servo clamp, resolved on the way into stage 2.
    assign dir        = distance_reg > target_distance_reg;
    assign brake_next = dir != prev_dir_reg;

    assign servo_lo    = $signed({2'b0, servo_center_reg}) - $signed({3'b0, servo_span_reg});
    assign servo_hi    = $signed({2'b0, servo_center_reg}) + $signed({3'b0, servo_span_reg});
    assign servo_cmd_s = $signed({2'b0, servo_cmd_reg});

    assign servo_raised  = (servo_cmd_s < servo_lo) ? servo_lo : servo_cmd_s;
    assign servo_clamped = (servo_raised > servo_hi) ? servo_hi : servo_raised;
    assign servo_next    = brake_next ? servo_center_reg : servo_clamped[13:0];

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            brake2_reg <= brake_next;
            servo2_reg <= servo_next;
        end
        if (adv.s3)
        begin
            brake3_reg <= brake2_reg;
            servo3_reg <= servo2_reg;
        end
    end

    // The drive clamp never exceeds the PWM period.
    assign drive_lim = ({3'b0, drive_limit_reg} > PERIOD_16) ? PERIOD_13 : drive_limit_reg;

    dipi_wheel #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_wheel_left (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .count        (count_left_reg),
        .goal         (goal_left_reg),
        .gain_p       (speed_gain_p_reg),
        .gain_i       (speed_gain_i_reg),
        .drive_lim    (drive_lim),
        .high_compare (lw_high),
        .low_compare  (lw_low)
    );

    dipi_wheel #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_wheel_right (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .count        (count_right_reg),
        .goal         (goal_right_reg),
        .gain_p       (speed_gain_p_reg),
        .gain_i       (speed_gain_i_reg),
        .drive_lim    (drive_lim),
        .high_compare (rw_high),
        .low_compare  (rw_low)
    );

    // Stage 4: result register.
    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            left_high_reg  <= brake3_reg ? PERIOD_13 : lw_high;
            left_low_reg   <= brake3_reg ? PERIOD_13 : lw_low;
            right_high_reg <= brake3_reg ? PERIOD_13 : rw_high;
            right_low_reg  <= brake3_reg ? PERIOD_13 : rw_low;
            servo_out_reg  <= servo3_reg;
            braking_reg    <= brake3_reg;
        end
    end

    assign out_valid          = v4_reg;
    assign left_high_compare  = left_high_reg;
    assign left_low_compare   = left_low_reg;
    assign right_high_compare = right_high_reg;
    assign right_low_compare  = right_low_reg;
    assign servo_out          = servo_out_reg;
    assign braking            = braking_reg;

    // A braking beat drives every compare to the period.
    a_brake_compares: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && braking |->
            left_high_compare == PERIOD_13 && left_low_compare == PERIOD_13 &&
            right_high_compare == PERIOD_13 && right_low_compare == PERIOD_13)
        else $error("Braking beat with a compare other than the period.");

    // In each bridge at least one side sits at the period.
    a_bridge_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !braking |->
            (left_high_compare == PERIOD_13 || left_low_compare == PERIOD_13) &&
            (right_high_compare == PERIOD_13 || right_low_compare == PERIOD_13))
        else $error("Both sides of an H-bridge are driven at once.");

    // A braking beat centers the servo.
    a_brake_servo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && braking |-> servo_out == servo_center_reg)
        else $error("Braking beat without a centered servo.");

endmodule

`default_nettype wire
